/* sv/leea_pkg.sv */
// Shared types and constants for the line end exclusive adjust block.
package leea_pkg;

    // Coordinate width of every point field.
    localparam int COORD_WIDTH = 16;
    // Width of the surface size registers.
    localparam int SIZE_WIDTH = 15;
    // Configuration port widths.
    localparam int CFG_DATA_WIDTH = 15;
    localparam int CFG_INDEX_WIDTH = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IN_PATH        = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SURFACE_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SURFACE_HEIGHT = 2'd2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
    } line_item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] adj_x;
        logic signed [COORD_WIDTH-1:0] adj_y;
    } adj_item_t;

    // Classified item passed from the front part to the back part.
    typedef struct packed {
        logic                          diag;
        logic                          neg_x;
        logic                          neg_y;
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic [COORD_WIDTH:0]          mag_x;
        logic [COORD_WIDTH:0]          mag_y;
        logic [2*COORD_WIDTH+1:0]      sq_x;
        logic [2*COORD_WIDTH+1:0]      sq_y;
        adj_item_t                     adj;
    } mid_item_t;

endpackage

/* sv/leea_fifo.sv */
// Small synchronous queue with registered storage.
module leea_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end
endmodule

/* sv/leea_front.sv */
// Front part: classifies a line and settles every case but the diagonal one.
module leea_front (
    input  leea_pkg::line_item_t                  item,
    input  logic                                  in_path,
    input  logic [leea_pkg::SIZE_WIDTH-1:0]       surface_width,
    input  logic [leea_pkg::SIZE_WIDTH-1:0]       surface_height,
    output leea_pkg::mid_item_t                   mid
);
    import leea_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic signed [CW:0] dx, dy;
    logic [CW:0]        mag_x, mag_y;
    logic [CW-1:0]      wmax, hmax;
    logic               clamp_x, clamp_y;
    logic               same_x, same_y;

    always_comb
    begin
        dx = $signed({item.end_x[CW-1], item.end_x}) - $signed({item.start_x[CW-1], item.start_x});
        dy = $signed({item.end_y[CW-1], item.end_y}) - $signed({item.start_y[CW-1], item.start_y});
        mag_x = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
        mag_y = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
        same_x = (item.start_x == item.end_x);
        same_y = (item.start_y == item.end_y);

        // A zero size register wraps the maximum to minus one.
        wmax = CW'({{(CW-SIZE_WIDTH){1'b0}}, surface_width} - 1'b1);
        hmax = CW'({{(CW-SIZE_WIDTH){1'b0}}, surface_height} - 1'b1);
        clamp_x = $signed({item.end_x[CW-1], item.end_x})
                  >= $signed({{(CW+1-SIZE_WIDTH){1'b0}}, surface_width});
        clamp_y = $signed({item.end_y[CW-1], item.end_y})
                  >= $signed({{(CW+1-SIZE_WIDTH){1'b0}}, surface_height});

        mid.diag    = 1'b0;
        mid.neg_x   = dx[CW];
        mid.neg_y   = dy[CW];
        mid.start_x = item.start_x;
        mid.start_y = item.start_y;
        mid.mag_x   = mag_x;
        mid.mag_y   = mag_y;
        mid.sq_x    = mag_x * mag_x;
        mid.sq_y    = mag_y * mag_y;
        mid.adj.adj_x = item.end_x;
        mid.adj.adj_y = item.end_y;

        if (in_path)
        begin
            mid.adj.adj_x = clamp_x ? wmax : item.end_x;
            mid.adj.adj_y = clamp_y ? hmax : item.end_y;
        end
        else if (same_x && same_y)
        begin
            mid.adj.adj_x = item.end_x;
        end
        else if (same_x)
        begin
            mid.adj.adj_y = dy[CW] ? item.end_y + 1'b1 : item.end_y - 1'b1;
        end
        else if (same_y)
        begin
            mid.adj.adj_x = dx[CW] ? item.end_x + 1'b1 : item.end_x - 1'b1;
        end
        else
        begin
            mid.diag = 1'b1;
        end
    end
endmodule

/* sv/leea_back.sv */
// Back part: pipelined square root and rounding for diagonal lines.
module leea_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  leea_pkg::mid_item_t  mid,
    input  logic                 mid_empty,
    output logic                 mid_pop,
    output leea_pkg::adj_item_t  res,
    input  logic                 res_full,
    output logic                 res_push
);
    import leea_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int N  = CW + 1 + FRAC_BITS;
    localparam int SW = 2 * CW + 2;
    localparam int RW = N + 2;

    logic            advance;
    logic            valid_reg [N+1];
    mid_item_t       info_reg  [N+1];
    logic [SW-1:0]   s_reg     [N+1];
    logic [N-1:0]    root_reg  [N+1];
    logic [RW-1:0]   rem_reg   [N+1];

    logic            f1_valid_reg;
    mid_item_t       f1_info_reg;
    logic [N-1:0]    f1_len_reg;
    logic [N-1:0]    rx_reg, ry_reg;
    logic            qx_reg, qy_reg;

    logic            f2_valid_reg;
    adj_item_t       f2_res_reg;

    // The whole pipeline holds only when a finished item cannot leave.
    assign advance  = !(f2_valid_reg && res_full);
    assign mid_pop  = advance && !mid_empty;
    assign res_push = f2_valid_reg && advance;
    assign res      = f2_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= !mid_empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            info_reg[0] <= mid;
            s_reg[0]    <= mid.sq_x + mid.sq_y;
            root_reg[0] <= '0;
            rem_reg[0]  <= '0;
        end
    end

    // One result bit per stage; the radicand shifts out two bits at a time.
    for (genvar k = 0; k < N; k++)
    begin : g_sqrt
        logic [RW+1:0] cur, trial, diff;
        logic          ge;

        always_comb
        begin
            cur   = {rem_reg[k], s_reg[k][SW-1:SW-2]};
            trial = {2'b00, root_reg[k], 2'b01};
            diff  = cur - trial;
            ge    = (cur >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                info_reg[k+1] <= info_reg[k];
                s_reg[k+1]    <= {s_reg[k][SW-3:0], 2'b00};
                root_reg[k+1] <= {root_reg[k][N-2:0], ge};
                rem_reg[k+1]  <= ge ? diff[RW-1:0] : cur[RW-1:0];
            end
        end
    end

    // The length is never below the axis magnitude in fraction units,
    // so the quotient is zero or one.
    logic [N-1:0] tx, ty;
    assign tx = {info_reg[N].mag_x, {FRAC_BITS{1'b0}}};
    assign ty = {info_reg[N].mag_y, {FRAC_BITS{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            f1_valid_reg <= valid_reg[N];
            f2_valid_reg <= f1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f1_info_reg <= info_reg[N];
            f1_len_reg  <= root_reg[N];
            qx_reg      <= (tx >= root_reg[N]);
            qy_reg      <= (ty >= root_reg[N]);
            rx_reg      <= (tx >= root_reg[N]) ? tx - root_reg[N] : tx;
            ry_reg      <= (ty >= root_reg[N]) ? ty - root_reg[N] : ty;
        end
    end

    logic [CW:0] mx, my;
    logic        round_x, round_y;
    adj_item_t   f2_next;

    always_comb
    begin
        round_x = ({rx_reg, 1'b0} > {1'b0, f1_len_reg});
        round_y = ({ry_reg, 1'b0} > {1'b0, f1_len_reg});
        mx = f1_info_reg.mag_x - (CW+1)'(qx_reg) - (CW+1)'(round_x);
        my = f1_info_reg.mag_y - (CW+1)'(qy_reg) - (CW+1)'(round_y);
        if (f1_info_reg.diag)
        begin
            f2_next.adj_x = f1_info_reg.neg_x ? f1_info_reg.start_x - mx[CW-1:0]
                                              : f1_info_reg.start_x + mx[CW-1:0];
            f2_next.adj_y = f1_info_reg.neg_y ? f1_info_reg.start_y - my[CW-1:0]
                                              : f1_info_reg.start_y + my[CW-1:0];
        end
        else
        begin
            f2_next = f1_info_reg.adj;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            f2_res_reg <= f2_next;
        end
    end
endmodule

/* sv/line_end_exclusive_adjust_top.sv */
// Top level of the line end exclusive adjust block.
//
// This block takes a line's start and end point and returns the end point
// moved so that the last pixel is left out. In path mode the end is only
// clamped to the surface size minus one. Otherwise a degenerate line keeps
// its end, an axis-aligned line steps its end one unit toward the start, and
// a diagonal line is shortened by one unit of Euclidean length with
// FRAC_BITS fraction bits, rounded half away from zero. The block takes one
// item per clock cycle while the result queue has room, and each item
// produces one result item. Each result passes through the square root
// pipeline, which resolves one bit of the fixed-point length per stage,
// and then the rounding registers before it enters the output queue.
// Configuration writes should only happen while no item is in flight.
module line_end_exclusive_adjust_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input queue side.
    input  logic                                  push,
    output logic                                  full,
    input  leea_pkg::line_item_t                  item,
    // Result queue side.
    output logic                                  empty,
    input  logic                                  pop,
    output leea_pkg::adj_item_t                   result,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [leea_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [leea_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
    import leea_pkg::*;

    logic                  in_path_reg;
    logic [SIZE_WIDTH-1:0] surface_width_reg;
    logic [SIZE_WIDTH-1:0] surface_height_reg;

    // Configuration registers; writes to unused indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_path_reg        <= 1'b0;
            surface_width_reg  <= {SIZE_WIDTH{1'b1}};
            surface_height_reg <= {SIZE_WIDTH{1'b1}};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IN_PATH:        in_path_reg        <= cfg_data[0];
                CFG_SURFACE_WIDTH:  surface_width_reg  <= cfg_data[SIZE_WIDTH-1:0];
                CFG_SURFACE_HEIGHT: surface_height_reg <= cfg_data[SIZE_WIDTH-1:0];
                default:            ;
            endcase
        end
    end

    // The front part classifies each item as it arrives. Its result goes
    // straight into a short queue, so the input accepts whenever that
    // queue has room.
    mid_item_t front_mid, back_mid;
    logic      mid_empty, mid_pop;

    leea_front u_front (
        .item           (item),
        .in_path        (in_path_reg),
        .surface_width  (surface_width_reg),
        .surface_height (surface_height_reg),
        .mid            (front_mid)
    );

    leea_fifo #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (2)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_mid),
        .full  (full),
        .pop   (mid_pop),
        .dout  (back_mid),
        .empty (mid_empty)
    );

    // The back part runs the length and rounding pipeline. It holds as a
    // whole only when its finished item cannot enter the result queue.
    adj_item_t back_res;
    logic      res_full, res_push;

    leea_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid       (back_mid),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .res       (back_res),
        .res_full  (res_full),
        .res_push  (res_push)
    );

    // The result queue lets the pipeline keep going while the consumer
    // has not yet taken the oldest result.
    leea_fifo #(
        .WIDTH ($bits(adj_item_t)),
        .DEPTH (2)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (back_res),
        .full  (res_full),
        .pop   (pop),
        .dout  (result),
        .empty (empty)
    );
endmodule

/* test/line_end_exclusive_adjust_checker.sv */
// Checker for the line end exclusive adjust block: predicts adjusted end points and compares.
`timescale 1ns / 1ps
module line_end_exclusive_adjust_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  leea_pkg::line_item_t item,
    input  logic                 empty,
    input  logic                 pop,
    input  leea_pkg::adj_item_t  result,
    input  logic                 cfg_we,
    input  logic [leea_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [leea_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                   fail_count,
    output int                   pending_count,
    output int                   result_count
);
    import leea_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic                  path_mode;
    logic [SIZE_WIDTH-1:0] width_reg;
    logic [SIZE_WIDTH-1:0] height_reg;
    adj_item_t             adj_expected_q[$];

    // Fixed-point length: floor(sqrt(s) * 2^FRAC_BITS), digit by digit.
    function automatic longint unsigned line_length_fixed(longint unsigned s);
        longint unsigned root;
        longint unsigned rem;
        longint unsigned trial;
        root = 0;
        rem = 0;
        for (int k = CW; k >= 0; k--)
        begin
            rem = (rem << 2) | ((s >> (2 * k)) & 64'd3);
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        for (int k = 0; k < FRAC_BITS; k++)
        begin
            rem = rem << 2;
            trial = (root << 2) | 64'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else
                root = root << 1;
        end
        return root;
    endfunction

    function automatic longint shorten(longint st, longint d, longint unsigned len);
        longint unsigned a;
        longint unsigned t;
        longint unsigned q;
        longint unsigned r;
        longint unsigned m;
        if (d == 0)
            return st;
        a = (d < 0) ? longint'(-d) : longint'(d);
        t = a << FRAC_BITS;
        q = t / len;
        r = t % len;
        m = a - q - ((2 * r > len) ? 64'd1 : 64'd0);
        return (d > 0) ? st + longint'(m) : st - longint'(m);
    endfunction

    function automatic adj_item_t exclusive_end(line_item_t li);
        longint sx;
        longint sy;
        longint ex;
        longint ey;
        longint ax;
        longint ay;
        longint dx;
        longint dy;
        longint unsigned len;
        adj_item_t res;
        sx = li.start_x;
        sy = li.start_y;
        ex = li.end_x;
        ey = li.end_y;
        if (path_mode)
        begin
            ax = (ex >= longint'(width_reg)) ? longint'(width_reg) - 1 : ex;
            ay = (ey >= longint'(height_reg)) ? longint'(height_reg) - 1 : ey;
        end
        else if (sx == ex && sy == ey)
        begin
            ax = ex;
            ay = ey;
        end
        else if (sx == ex)
        begin
            ax = ex;
            ay = (ey > sy) ? ey - 1 : ey + 1;
        end
        else if (sy == ey)
        begin
            ax = (ex > sx) ? ex - 1 : ex + 1;
            ay = ey;
        end
        else
        begin
            dx = ex - sx;
            dy = ey - sy;
            len = line_length_fixed(longint'(dx * dx + dy * dy));
            ax = shorten(sx, dx, len);
            ay = shorten(sy, dy, len);
        end
        res.adj_x = ax[CW-1:0];
        res.adj_y = ay[CW-1:0];
        return res;
    endfunction

    assign pending_count = adj_expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        adj_item_t exp_item;
        if (!rst_n)
        begin
            path_mode <= 1'b0;
            width_reg <= '1;
            height_reg <= '1;
            adj_expected_q.delete();
            fail_count <= 0;
            result_count <= 0;
        end
        else
        begin
            if (push && !full)
                adj_expected_q.push_back(exclusive_end(item));
            if (pop && !empty)
            begin
                result_count <= result_count + 1;
                if (adj_expected_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result %0d,%0d", $realtime,
                                 result.adj_x, result.adj_y);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_item = adj_expected_q.pop_front();
                    if (exp_item.adj_x !== result.adj_x || exp_item.adj_y !== result.adj_y)
                    begin
                        if (fail_count < 10)
                            $display("%0t: expected %0d,%0d got %0d,%0d", $realtime,
                                     exp_item.adj_x, exp_item.adj_y,
                                     result.adj_x, result.adj_y);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IN_PATH:        path_mode <= cfg_data[0];
                    CFG_SURFACE_WIDTH:  width_reg <= cfg_data[SIZE_WIDTH-1:0];
                    CFG_SURFACE_HEIGHT: height_reg <= cfg_data[SIZE_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

/* test/line_end_exclusive_adjust_top_tb.sv */
// Testbench top for the line end exclusive adjust block: stimulus and verdict.
`timescale 1ns / 1ps
module line_end_exclusive_adjust_top_tb;
    import leea_pkg::*;

    // Drain wait derived from the pipeline length at the default fraction width.
    localparam int LATENCY = COORD_WIDTH + 16 + 5;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    line_item_t  item = '0;
    logic        empty;
    logic        pop = 1'b0;
    adj_item_t   result;
    logic        cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = CFG_IN_PATH;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    int  fail_count;
    int  pending_count;
    int  result_count;
    int  lines_sent = 0;
    // Idle percentage of the receiver; zero gives a stretch without gaps.
    int  pop_idle_pct = 38;
    // While set, the receiver holds off entirely so the block fills up.
    bit  pop_hold = 1'b0;
    bit  saw_full = 1'b0;

    always #10 clk = ~clk;

    line_end_exclusive_adjust_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    line_end_exclusive_adjust_checker i_checker (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .item(item),
        .empty(empty), .pop(pop), .result(result),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    // The receiver decides each cycle whether it is ready to take a result.
    always @(posedge clk)
    begin
        if (rst_n)
            pop <= !pop_hold && ($urandom_range(99) >= pop_idle_pct);
    end

    always @(posedge clk)
    begin
        if (full && push)
            saw_full <= 1'b1;
    end

    // Offers one line item, with a random gap first, and holds it until taken.
    // Push stays high afterwards so that items can follow back to back; the
    // caller drops it before any pause.
    task automatic send_line(input line_item_t li, input int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        push <= 1'b1;
        item <= li;
        @(posedge clk);
        while (full)
            @(posedge clk);
        lines_sent++;
    endtask

    task automatic send_coords(input int sx, input int sy, input int ex, input int ey);
        line_item_t li;
        li.start_x = sx[15:0];
        li.start_y = sy[15:0];
        li.end_x = ex[15:0];
        li.end_y = ey[15:0];
        send_line(li, 0);
    endtask

    // Configuration is written only once the pipeline has drained.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input int val);
        push <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CFG_DATA_WIDTH-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(4))
            0: return 16'($urandom_range(65535));
            1: return 16'($urandom_range(40));
            2: return 16'(-$urandom_range(40));
            3: return 16'($urandom_range(32767, 32700));
            default: return 16'(-$urandom_range(32768, 32700));
        endcase
    endfunction

    // Random lines, mostly diagonal, some axis-aligned or degenerate.
    task automatic random_lines(input int count);
        line_item_t li;
        for (int n = 0; n < count; n++)
        begin
            li.start_x = rand_coord();
            li.start_y = rand_coord();
            li.end_x = rand_coord();
            li.end_y = rand_coord();
            case ($urandom_range(9))
                0: li.end_x = li.start_x;
                1: li.end_y = li.start_y;
                2: li = '{li.start_x, li.start_y, li.start_x, li.start_y};
                3:
                begin
                    li.end_x = li.start_x + 16'($urandom_range(7)) - 16'd3;
                    li.end_y = li.start_y + 16'($urandom_range(7)) - 16'd3;
                end
                default: ;
            endcase
            send_line(li, 38);
        end
    endtask

    initial
    begin
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines at reset settings: degenerate, axis-aligned in each
        // direction, diagonals including the full coordinate span.
        send_coords(5, 5, 5, 5);
        send_coords(0, 0, 0, 10);
        send_coords(0, 10, 0, 0);
        send_coords(0, 0, 10, 0);
        send_coords(10, 0, 0, 0);
        send_coords(0, 0, 3, 4);
        send_coords(0, 0, -3, -4);
        send_coords(0, 0, 1, 1);
        send_coords(-32768, -32768, 32767, 32767);
        send_coords(32767, -32768, -32768, 32767);
        send_coords(-32768, 0, 32767, 0);
        send_coords(0, 32767, 0, -32768);
        send_coords(100, 200, 101, 250);

        // Path mode clamping, including the smallest and largest surface.
        write_reg(CFG_IN_PATH, 1);
        write_reg(CFG_SURFACE_WIDTH, 1);
        write_reg(CFG_SURFACE_HEIGHT, 32767);
        send_coords(0, 0, 5, 32767);
        send_coords(0, 0, -32768, 32766);
        send_coords(0, 0, 0, -1);
        write_reg(CFG_SURFACE_WIDTH, 640);
        write_reg(CFG_SURFACE_HEIGHT, 480);
        send_coords(0, 0, 639, 479);
        send_coords(0, 0, 640, 480);
        send_coords(0, 0, 32767, -32768);
        // A zero surface size lies outside the range but clamps to minus one.
        write_reg(CFG_SURFACE_WIDTH, 0);
        send_coords(0, 0, 0, 1000);
        random_lines(150);

        // Back to shortening mode, with a long stretch without idling.
        write_reg(CFG_IN_PATH, 0);
        pop_idle_pct = 0;
        for (int n = 0; n < 100; n++)
        begin
            line_item_t li;
            li = {16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
            send_line(li, 0);
        end
        pop_idle_pct = 38;

        // The receiver holds off while items keep coming, to fill the block.
        fork
            begin
                pop_hold = 1'b1;
                repeat (150)
                    @(posedge clk);
                pop_hold = 1'b0;
            end
            random_lines(80);
        join

        random_lines(250);
        write_reg(CFG_IN_PATH, 1);
        write_reg(CFG_SURFACE_WIDTH, 32767);
        write_reg(CFG_SURFACE_HEIGHT, 1);
        random_lines(150);

        push <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY)
            @(posedge clk);
        $display("Sent %0d lines, checked %0d results; path mode and shortening",
                 lines_sent, result_count);
        $display("covered, with surface sizes from 0 to 32767, input stall seen: %0d",
                 saw_full);
        if (fail_count == 0)
            $display("line_end_exclusive_adjust_top: match");
        else
            $display("line_end_exclusive_adjust_top: mismatch");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("line_end_exclusive_adjust_top: mismatch");
        $finish;
    end
endmodule

/* line_end_exclusive_adjust_top.f */
sv/leea_pkg.sv
sv/leea_fifo.sv
sv/leea_front.sv
sv/leea_back.sv
sv/line_end_exclusive_adjust_top.sv
test/line_end_exclusive_adjust_checker.sv
test/line_end_exclusive_adjust_top_tb.sv
